// File: rtl/core/nfsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nfsa_pkg;

    localparam int HANDLE_W = 31;
    localparam int SLOT_W   = 5;

    typedef enum logic [1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_FREE   = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_BAD   = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]          command;
        logic [HANDLE_W-1:0] handle_value;
        logic [SLOT_W-1:0]   slot_number;
    } t_in_item;

    typedef struct packed {
        logic [SLOT_W-1:0]   result_slot;
        logic [HANDLE_W-1:0] result_handle;
        logic [1:0]          status;
    } t_out_item;

    typedef enum logic {
        CTL_IDLE = 1'b0,
        CTL_WORK = 1'b1
    } t_ctl_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic exec;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_room;
    } t_dp_sts;

endpackage

`default_nettype wire

// File: rtl/core/nfsa_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module nfsa_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/core/nfsa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module nfsa_ctrl
    import nfsa_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_ctl_state r_state;
    t_ctl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CTL_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            CTL_IDLE: begin
                if (i_in_valid) begin
                    n_state = CTL_WORK;
                end
            end
            CTL_WORK: begin
                if (i_sts.out_room) begin
                    n_state = CTL_IDLE;
                end
            end
            default: n_state = CTL_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall  = 1'b1;
        o_cmd.latch = 1'b0;
        o_cmd.exec  = 1'b0;
        unique case (r_state)
            CTL_IDLE: begin
                o_in_stall  = 1'b0;
                o_cmd.latch = i_in_valid;
            end
            CTL_WORK: begin
                o_cmd.exec = i_sts.out_room;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/nfsa_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module nfsa_dp
    import nfsa_pkg::*;
#(
    parameter int SLOT_COUNT = 16,
    parameter int AW         = 4
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_in_item i_in_data,
    input  wire t_dp_cmd  i_cmd,
    output t_dp_sts       o_sts,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_item     o_out_data
);

    t_in_item            r_req;
    logic [SLOT_COUNT-1:0] r_occ;
    logic [SLOT_COUNT-1:0] n_occ;
    logic [AW-1:0]       r_ptr;
    logic [AW-1:0]       n_ptr;
    logic                r_out_valid;
    t_out_item           r_out_data;
    t_out_item           n_out_data;

    logic [SLOT_W-1:0]   in_slot_m1;
    logic [SLOT_W-1:0]   req_slot_m1;
    logic [AW-1:0]       rd_idx;
    logic [AW-1:0]       req_idx;
    logic                in_range;
    logic [HANDLE_W-1:0] rdata;

    logic                ram_we;
    logic                found_hi;
    logic                found_any;
    logic [AW-1:0]       idx_hi;
    logic [AW-1:0]       idx_any;
    logic [AW-1:0]       grant_idx;

    assign in_slot_m1  = i_in_data.slot_number - SLOT_W'(1);
    assign req_slot_m1 = r_req.slot_number - SLOT_W'(1);
    assign rd_idx      = AW'(in_slot_m1);
    assign req_idx     = AW'(req_slot_m1);
    assign in_range    = (r_req.slot_number != '0)
                         && (32'(r_req.slot_number) <= 32'(SLOT_COUNT));

    // Rotating priority search: the lowest free slot at or after the pointer
    // wins, and failing that the lowest free slot overall, which is the wrap.
    always_comb begin
        found_hi  = 1'b0;
        found_any = 1'b0;
        idx_hi    = '0;
        idx_any   = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!r_occ[i]) begin
                found_any = 1'b1;
                idx_any   = AW'(i);
                if (AW'(i) >= r_ptr) begin
                    found_hi = 1'b1;
                    idx_hi   = AW'(i);
                end
            end
        end
        grant_idx = found_hi ? idx_hi : idx_any;
    end

    always_comb begin
        n_occ      = r_occ;
        n_ptr      = r_ptr;
        ram_we     = 1'b0;
        n_out_data = '0;
        case (t_cmd'(r_req.command))
            CMD_ALLOC: begin
                if (r_req.handle_value == '0) begin
                    n_out_data.status = ST_BAD;
                end else if (found_any) begin
                    n_out_data.result_slot = SLOT_W'(32'(grant_idx) + 32'd1);
                    n_out_data.status      = ST_OK;
                    n_occ[grant_idx]       = 1'b1;
                    n_ptr                  = grant_idx;
                    ram_we                 = 1'b1;
                end else begin
                    n_out_data.status = ST_FULL;
                end
            end
            CMD_LOOKUP: begin
                n_out_data.result_slot = r_req.slot_number;
                if (!in_range) begin
                    n_out_data.status = ST_BAD;
                end else begin
                    n_out_data.status        = ST_OK;
                    n_out_data.result_handle = r_occ[req_idx] ? rdata : '0;
                end
            end
            CMD_FREE: begin
                n_out_data.result_slot = r_req.slot_number;
                if (!in_range) begin
                    n_out_data.status = ST_BAD;
                end else if (!r_occ[req_idx]) begin
                    n_out_data.status = ST_EMPTY;
                end else begin
                    n_out_data.status = ST_OK;
                    n_occ[req_idx]    = 1'b0;
                end
            end
            CMD_CLEAR: begin
                n_occ             = '0;
                n_out_data.status = ST_OK;
            end
            default: begin
                n_out_data.status = ST_BAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req <= i_in_data;
        end
        if (i_cmd.exec) begin
            r_out_data <= n_out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_occ       <= n_occ;
                r_ptr       <= n_ptr;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Stored handles are only trusted where the occupancy flag is set, so the
    // memory itself never needs clearing.
    nfsa_ram #(
        .WIDTH (HANDLE_W),
        .DEPTH (SLOT_COUNT),
        .AW    (AW)
    ) u_handles (
        .i_clk   (i_clk),
        .i_we    (i_cmd.exec && ram_we),
        .i_waddr (grant_idx),
        .i_wdata (r_req.handle_value),
        .i_re    (i_cmd.latch),
        .i_raddr (rd_idx),
        .o_rdata (rdata)
    );

    assign o_sts.out_room = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out_data;

endmodule

`default_nettype wire

// File: rtl/core/next_fit_slot_allocator_top.sv
// Timing: a command transfer loads the request register and starts the handle
// memory's registered read; the block then enters its work state, where the
// allocation search and update run and the result is registered once the output
// has room. No new command is taken until that result has been registered.
// A waiting result holds the block in its work state until it is taken.
// Reset (synchronous, active low) empties all slots at once through the
// occupancy flags and points the search at slot 1; no clearing pass follows.
`timescale 1ns / 1ps
`default_nettype none

module next_fit_slot_allocator_top
    import nfsa_pkg::*;
#(
    parameter int SLOT_COUNT = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_item     o_out_data
);

    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    nfsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    nfsa_dp #(
        .SLOT_COUNT (SLOT_COUNT),
        .AW         (AW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// File: test/next_fit_slot_allocator_top_tb.sv
`timescale 1ns / 1ps

module next_fit_slot_allocator_top_tb;
    import nfsa_pkg::*;

    localparam int SLOT_COUNT = 16;
    localparam int CYCLE_LIMIT = 100000;
    localparam int RANDOM_CMDS = 550;
    localparam int QUIET_FROM = 490;
    localparam int PAUSE_AT = 250;

    typedef struct {
        t_cmd                cmd;
        logic [HANDLE_W-1:0] handle;
        logic [SLOT_W-1:0]   slot;
        int                  reps;
        bit                  fixed;
        t_out_item           reply;
    } t_cmd_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    // Shadow copy of the slot table and the next-fit search pointer.
    logic [HANDLE_W-1:0] shadow_handles [SLOT_COUNT];
    int                  shadow_ptr;

    t_out_item replies_due [$];
    t_cmd_row  cmd_rows [$];
    int        err_count = 0;
    int        cycle_count = 0;
    int        stall_left = 0;
    bit        no_idle = 1'b0;
    t_out_item want;

    next_fit_slot_allocator_top #(
        .SLOT_COUNT(SLOT_COUNT)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t timeout with %0d replies outstanding", $time, replies_due.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Applies one command to the shadow table and returns the reply it causes.
    task automatic apply_slot_cmd(input t_in_item it, output t_out_item r);
        int  k;
        bit  found;
        r = '0;
        found = 1'b0;
        case (t_cmd'(it.command))
            CMD_ALLOC: begin
                if (it.handle_value == '0) begin
                    r.status = ST_BAD;
                end else begin
                    for (k = 0; k < SLOT_COUNT; k++) begin
                        if (!found) begin
                            if (shadow_handles[shadow_ptr] == '0) begin
                                shadow_handles[shadow_ptr] = it.handle_value;
                                r.result_slot = SLOT_W'(shadow_ptr + 1);
                                found = 1'b1;
                            end else begin
                                shadow_ptr = (shadow_ptr + 1) % SLOT_COUNT;
                            end
                        end
                    end
                    r.status = found ? ST_OK : ST_FULL;
                end
            end
            CMD_LOOKUP, CMD_FREE: begin
                r.result_slot = it.slot_number;
                if (it.slot_number < 1 || it.slot_number > SLOT_COUNT) begin
                    r.status = ST_BAD;
                end else if (t_cmd'(it.command) == CMD_LOOKUP) begin
                    r.result_handle = shadow_handles[it.slot_number - 1];
                    r.status = ST_OK;
                end else if (shadow_handles[it.slot_number - 1] == '0) begin
                    r.status = ST_EMPTY;
                end else begin
                    shadow_handles[it.slot_number - 1] = '0;
                    r.status = ST_OK;
                end
            end
            default: begin
                for (k = 0; k < SLOT_COUNT; k++) shadow_handles[k] = '0;
                r.status = ST_OK;
            end
        endcase
    endtask

    // Presents one command, waits for its transfer and records the reply it is owed.
    // With hold_after set, the sender stops until every owed reply has come back.
    task automatic send_cmd(input t_in_item it, input bit fixed, input t_out_item fixed_reply,
                            input bit hold_after);
        t_out_item guess;
        int        gap;
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        apply_slot_cmd(it, guess);
        replies_due.push_back(fixed ? fixed_reply : guess);
        gap = 0;
        if (!no_idle && $urandom_range(0, 99) < 20) gap = $urandom_range(1, 9);
        if (hold_after || gap > 0) begin
            i_in_valid <= 1'b0;
            if (hold_after) begin
                while (replies_due.size() != 0) @(posedge i_clk);
            end
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic add_row(input t_cmd c, input logic [HANDLE_W-1:0] h,
                           input logic [SLOT_W-1:0] s, input int reps, input bit fixed,
                           input logic [SLOT_W-1:0] rs, input logic [HANDLE_W-1:0] rh,
                           input t_status st);
        t_cmd_row row;
        row.cmd = c;
        row.handle = h;
        row.slot = s;
        row.reps = reps;
        row.fixed = fixed;
        row.reply.result_slot = rs;
        row.reply.result_handle = rh;
        row.reply.status = st;
        cmd_rows.push_back(row);
    endtask

    // Receiving side: checks each transferred reply and stalls in random bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (replies_due.size() == 0) begin
                    $display("%0t unexpected reply: expected none actual %h", $time, o_out_data);
                    err_count++;
                end else begin
                    want = replies_due.pop_front();
                    if (o_out_data.result_slot !== want.result_slot) begin
                        $display("%0t result_slot: expected %0d actual %0d", $time,
                                 want.result_slot, o_out_data.result_slot);
                        err_count++;
                    end
                    if (o_out_data.result_handle !== want.result_handle) begin
                        $display("%0t result_handle: expected %h actual %h", $time,
                                 want.result_handle, o_out_data.result_handle);
                        err_count++;
                    end
                    if (o_out_data.status !== want.status) begin
                        $display("%0t status: expected %0d actual %0d", $time,
                                 want.status, o_out_data.status);
                        err_count++;
                    end
                end
            end
            if (stall_left == 0 && !no_idle && $urandom_range(0, 99) < 15) begin
                stall_left = $urandom_range(1, 9);
            end
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        t_in_item  it;
        t_out_item none;
        int        n;
        int        r;
        int        pick;
        none = '0;
        for (n = 0; n < SLOT_COUNT; n++) shadow_handles[n] = '0;
        shadow_ptr = 0;

        // Directed part: errors on an empty table, filling it, the full case,
        // freeing and reallocating with wrap-around, and clear-all.
        add_row(CMD_LOOKUP, 31'h0, 5'd1, 1, 1, 5'd1, 31'h0, ST_OK);
        add_row(CMD_FREE, 31'h0, 5'd1, 1, 1, 5'd1, 31'h0, ST_EMPTY);
        add_row(CMD_ALLOC, 31'h0, 5'd7, 1, 1, 5'd0, 31'h0, ST_BAD);
        add_row(CMD_LOOKUP, 31'h1, 5'd0, 1, 1, 5'd0, 31'h0, ST_BAD);
        add_row(CMD_LOOKUP, 31'h0, 5'd17, 1, 1, 5'd17, 31'h0, ST_BAD);
        add_row(CMD_FREE, 31'h7FFFFFFF, 5'd31, 1, 1, 5'd31, 31'h0, ST_BAD);
        add_row(CMD_ALLOC, 31'h7FFFFFFF, 5'd0, 1, 1, 5'd1, 31'h0, ST_OK);
        add_row(CMD_LOOKUP, 31'h0, 5'd1, 1, 1, 5'd1, 31'h7FFFFFFF, ST_OK);
        add_row(CMD_ALLOC, 31'h1, 5'd31, 1, 1, 5'd2, 31'h0, ST_OK);
        add_row(CMD_ALLOC, 31'h2AAAAAAA, 5'd0, SLOT_COUNT - 2, 0, 5'd0, 31'h0, ST_OK);
        add_row(CMD_ALLOC, 31'h01234567, 5'd5, 1, 1, 5'd0, 31'h0, ST_FULL);
        add_row(CMD_LOOKUP, 31'h0, 5'd16, 1, 0, 5'd0, 31'h0, ST_OK);
        add_row(CMD_FREE, 31'h0, 5'd16, 1, 1, 5'd16, 31'h0, ST_OK);
        add_row(CMD_FREE, 31'h0, 5'd16, 1, 1, 5'd16, 31'h0, ST_EMPTY);
        add_row(CMD_ALLOC, 31'h55555555, 5'd0, 1, 0, 5'd0, 31'h0, ST_OK);
        add_row(CMD_FREE, 31'h0, 5'd3, 1, 1, 5'd3, 31'h0, ST_OK);
        add_row(CMD_ALLOC, 31'h0F0F0F0F, 5'd0, 1, 0, 5'd0, 31'h0, ST_OK);
        add_row(CMD_LOOKUP, 31'h0, 5'd3, 1, 0, 5'd0, 31'h0, ST_OK);
        add_row(CMD_CLEAR, 31'h7FFFFFFF, 5'd31, 1, 1, 5'd0, 31'h0, ST_OK);
        add_row(CMD_LOOKUP, 31'h0, 5'd16, 1, 1, 5'd16, 31'h0, ST_OK);
        add_row(CMD_ALLOC, 31'h9, 5'd0, 1, 0, 5'd0, 31'h0, ST_OK);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (cmd_rows[i]) begin
            for (r = 0; r < cmd_rows[i].reps; r++) begin
                it.command = cmd_rows[i].cmd;
                it.handle_value = cmd_rows[i].handle;
                it.slot_number = cmd_rows[i].slot;
                send_cmd(it, cmd_rows[i].fixed, cmd_rows[i].reply, 1'b0);
            end
        end

        // Random part: allocate and free dominate so the table keeps filling up
        // and draining; clear-all is rare so the full case is still reached.
        for (n = 0; n < RANDOM_CMDS; n++) begin
            no_idle = (n >= QUIET_FROM);
            pick = $urandom_range(0, 99);
            if (pick < 42) it.command = CMD_ALLOC;
            else if (pick < 67) it.command = CMD_LOOKUP;
            else if (pick < 95) it.command = CMD_FREE;
            else it.command = CMD_CLEAR;
            case ($urandom_range(0, 19))
                0: it.handle_value = '0;
                1: it.handle_value = 31'h7FFFFFFF;
                2: it.handle_value = 31'h1;
                default: it.handle_value = HANDLE_W'($urandom);
            endcase
            if ($urandom_range(0, 9) == 0) it.slot_number = SLOT_W'($urandom_range(0, 31));
            else it.slot_number = SLOT_W'($urandom_range(1, SLOT_COUNT));
            send_cmd(it, 1'b0, none, (n == PAUSE_AT) || (n == RANDOM_CMDS - 1));
        end

        repeat (10) @(posedge i_clk);
        if (err_count == 0 && replies_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
